/* rtl/core/rqu8_pkg.sv */
`timescale 1ns / 1ps
package rqu8_pkg;

    localparam int LANES   = 4;
    localparam int ACC_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int MULT_W  = 24;
    localparam int PROD_W  = ACC_W + MULT_W;
    localparam int SHIFT_W = 6;
    localparam int SCALE_W = 30;
    localparam int BOUND_W = 10;
    localparam int IDX_W   = 2;

    localparam logic [22:0] MANT_MASK  = 23'h7F_FFFF;
    localparam logic [23:0] HIDDEN_BIT = 24'h80_0000;
    localparam int          MANT_BITS  = 23;
    localparam int          SHIFT_BASE = 127 + 23;
    localparam int          SHIFT_LO   = 24;
    localparam int          SHIFT_HI   = 55;

    localparam logic [IDX_W-1:0] REG_SCALE = 2'd0;
    localparam logic [IDX_W-1:0] REG_ZP    = 2'd1;
    localparam logic [IDX_W-1:0] REG_MIN   = 2'd2;
    localparam logic [IDX_W-1:0] REG_MAX   = 2'd3;

    localparam logic [SCALE_W-1:0] SCALE_RST = 30'h3F00_0000;

    // Values derived from the configuration, shared by all lanes.
    typedef struct packed {
        logic [MULT_W-1:0]         mult;
        logic [SHIFT_W-1:0]        shift;
        logic signed [BOUND_W-1:0] lo;
        logic signed [BOUND_W-1:0] hi;
        logic [BYTE_W-1:0]         zp;
    } t_rq_cfg;

    // Load enables of the lane pipeline stages.
    typedef struct packed {
        logic s0;
        logic s1;
        logic s2;
    } t_rq_en;

endpackage

/* rtl/core/rqu8_lane.sv */
`timescale 1ns / 1ps
module rqu8_lane (
    input  logic                           i_clk,
    input  rqu8_pkg::t_rq_en               i_en,
    input  rqu8_pkg::t_rq_cfg              i_cfg,
    input  logic [rqu8_pkg::ACC_W-1:0]     i_acc,
    output logic [rqu8_pkg::BYTE_W-1:0]    o_byte
);
    import rqu8_pkg::*;

    logic [ACC_W-1:0]  r_mag;
    logic              r_neg0;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg1;
    logic [ACC_W-1:0]  r_res;
    logic              r_neg2;

    logic [ACC_W-1:0]  n_mag;
    logic [PROD_W:0]   n_sum;
    logic [PROD_W:0]   n_shifted;
    logic [PROD_W:0]   n_half;
    logic [BOUND_W:0]  n_sat;
    logic signed [BOUND_W:0] n_val;
    logic signed [BOUND_W:0] n_clamp;
    logic [BOUND_W:0]  n_out;

    // Two's complement negate; the most negative value maps to 2^31 exactly.
    assign n_mag = i_acc[ACC_W-1] ? (~i_acc + 1'b1) : i_acc;

    assign n_half    = {{PROD_W{1'b0}}, 1'b1} << (i_cfg.shift - 1'b1);
    assign n_sum     = {1'b0, r_prod} + n_half;
    assign n_shifted = n_sum >> i_cfg.shift;

    // The magnitude is saturated before the sign is restored; the bounds never
    // exceed 255 in magnitude, so this does not change the clamped value.
    always_comb begin
        n_sat = (r_res > ACC_W'(2 ** BOUND_W - 1)) ? {1'b0, {BOUND_W{1'b1}}}
                                                  : {1'b0, r_res[BOUND_W-1:0]};
        n_val = r_neg2 ? -$signed(n_sat) : $signed(n_sat);
        n_clamp = n_val;
        if (n_clamp < $signed({i_cfg.lo[BOUND_W-1], i_cfg.lo})) begin
            n_clamp = $signed({i_cfg.lo[BOUND_W-1], i_cfg.lo});
        end
        if (n_clamp > $signed({i_cfg.hi[BOUND_W-1], i_cfg.hi})) begin
            n_clamp = $signed({i_cfg.hi[BOUND_W-1], i_cfg.hi});
        end
        n_out = n_clamp + {{(BOUND_W + 1 - BYTE_W){1'b0}}, i_cfg.zp};
    end

    assign o_byte = n_out[BYTE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en.s0) begin
            r_mag  <= n_mag;
            r_neg0 <= i_acc[ACC_W-1];
        end
        if (i_en.s1) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(i_cfg.mult);
            r_neg1 <= r_neg0;
        end
        if (i_en.s2) begin
            r_res  <= n_shifted[ACC_W-1:0];
            r_neg2 <= r_neg1;
        end
    end

endmodule

/* rtl/core/rqu8_out.sv */
`timescale 1ns / 1ps
module rqu8_out (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_load,
    input  logic                                      i_vld,
    input  logic                                      i_last,
    input  logic [rqu8_pkg::LANES*rqu8_pkg::BYTE_W-1:0] i_bytes,
    input  logic                                      i_ready,
    output logic                                      o_vld,
    output logic                                      o_last,
    output logic [rqu8_pkg::LANES*rqu8_pkg::BYTE_W-1:0] o_bytes,
    output logic                                      o_free
);
    import rqu8_pkg::*;

    logic                      r_vld;
    logic                      r_last;
    logic [LANES*BYTE_W-1:0]   r_bytes;

    // The word register can take new data when empty or when being drained.
    assign o_free  = !r_vld || i_ready;
    assign o_vld   = r_vld;
    assign o_last  = r_last;
    assign o_bytes = r_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_last  <= i_last;
            r_bytes <= i_bytes;
        end
    end

endmodule

/* rtl/core/requantize_int32_to_uint8_top.sv */
`timescale 1ns / 1ps
// An input word passes stage registers s0, s1, s2 and the output register.
// Throughput: one word of four lanes per cycle when output is not stalled;
// own multiplier per lane; stages advance independently, filling bubbles.
// Reset (synchronous, active low) empties the pipeline and loads the scale
// with 0.5, zero point 0, minimum 0 and maximum 255.
module requantize_int32_to_uint8_top (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_we,
    input  logic [rqu8_pkg::IDX_W-1:0]                  i_cfg_idx,
    input  logic [rqu8_pkg::SCALE_W-1:0]                i_cfg_data,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // acc_lane0, acc_lane1, acc_lane2, acc_lane3 (32 bits each, signed)
    input  logic [rqu8_pkg::LANES*rqu8_pkg::ACC_W-1:0]  s_axis_tdata,
    input  logic                                        s_axis_tlast,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // byte_lane0, byte_lane1, byte_lane2, byte_lane3 (8 bits each)
    output logic [rqu8_pkg::LANES*rqu8_pkg::BYTE_W-1:0] m_axis_tdata,
    output logic                                        m_axis_tlast
);
    import rqu8_pkg::*;

    logic [SCALE_W-1:0] r_scale;
    logic [BYTE_W-1:0]  r_zp;
    logic [BYTE_W-1:0]  r_min;
    logic [BYTE_W-1:0]  r_max;

    logic [6:0]         n_exp;
    t_rq_cfg            n_cfg;
    t_rq_en             n_en;
    logic               n_out_free;

    logic               r_v0, r_v1, r_v2;
    logic               r_l0, r_l1, r_l2;

    logic [LANES*BYTE_W-1:0] n_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RST;
            r_zp    <= '0;
            r_min   <= '0;
            r_max   <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SCALE: r_scale <= i_cfg_data;
                REG_ZP:    r_zp    <= i_cfg_data[BYTE_W-1:0];
                REG_MIN:   r_min   <= i_cfg_data[BYTE_W-1:0];
                REG_MAX:   r_max   <= i_cfg_data[BYTE_W-1:0];
                default:   ;
            endcase
        end
    end

    // Shift is 150 minus the exponent, held within 24..55.
    assign n_exp = r_scale[MANT_BITS +: 7];

    always_comb begin
        n_cfg.mult = {1'b0, r_scale[MANT_BITS-1:0] & MANT_MASK} | HIDDEN_BIT;
        priority if (n_exp >= 7'(SHIFT_BASE - SHIFT_LO)) begin
            n_cfg.shift = SHIFT_W'(SHIFT_LO);
        end else if (n_exp <= 7'(SHIFT_BASE - SHIFT_HI)) begin
            n_cfg.shift = SHIFT_W'(SHIFT_HI);
        end else begin
            n_cfg.shift = SHIFT_W'(8'(SHIFT_BASE) - {1'b0, n_exp});
        end
        n_cfg.lo = $signed({2'b00, r_min}) - $signed({2'b00, r_zp});
        n_cfg.hi = $signed({2'b00, r_max}) - $signed({2'b00, r_zp});
        n_cfg.zp = r_zp;
    end

    // Each stage loads when it is empty or its contents move on.
    assign n_en.s2 = !r_v2 || n_out_free;
    assign n_en.s1 = !r_v1 || n_en.s2;
    assign n_en.s0 = !r_v0 || n_en.s1;
    assign s_axis_tready = n_en.s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (n_en.s0) r_v0 <= s_axis_tvalid;
            if (n_en.s1) r_v1 <= r_v0;
            if (n_en.s2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en.s0) r_l0 <= s_axis_tlast;
        if (n_en.s1) r_l1 <= r_l0;
        if (n_en.s2) r_l2 <= r_l1;
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        rqu8_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (n_en),
            .i_cfg  (n_cfg),
            .i_acc  (s_axis_tdata[g*ACC_W +: ACC_W]),
            .o_byte (n_bytes[g*BYTE_W +: BYTE_W])
        );
    end

    rqu8_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (n_out_free),
        .i_vld   (r_v2),
        .i_last  (r_l2),
        .i_bytes (n_bytes),
        .i_ready (m_axis_tready),
        .o_vld   (m_axis_tvalid),
        .o_last  (m_axis_tlast),
        .o_bytes (m_axis_tdata),
        .o_free  (n_out_free)
    );

endmodule
